>>> sv/tmf_pkg.sv
// ----------------------------------------------------------------------------
// tmf_pkg - shared types and constants of the temporal median filter
// Field widths, frame counter limits and result lag codes.
// ----------------------------------------------------------------------------
package tmf_pkg;

  localparam int MAG_W    = 16;   // bin magnitude
  localparam int BIN_W    = 8;    // bin index on the result channel
  localparam int CFG_W    = 9;    // bins_per_frame register
  localparam int FS_W     = 3;    // completed frames counter
  localparam int OUT_DW   = 32;   // result tdata, padded to whole bytes

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;
  localparam logic [FS_W-1:0]  FS_ONE    = 3'd1;
  localparam logic [FS_W-1:0]  FS_TWO    = 3'd2;
  localparam logic [FS_W-1:0]  FS_FULL   = 3'd4;

  // frames behind the current input frame that a result belongs to
  typedef enum logic [1:0] {
    LAG_NOW  = 2'd0,
    LAG_ONE  = 2'd1,
    LAG_TWO  = 2'd2
  } lag_t;

  typedef logic [MAG_W-1:0] mag_t;

endpackage

>>> sv/tmf_median5.sv
// ----------------------------------------------------------------------------
// tmf_median5 - median of five magnitudes
// All pairwise compares in parallel; each value gets its stable rank and the
// value of rank two is the median.
// ----------------------------------------------------------------------------
module tmf_median5
  import tmf_pkg::*;
(
  input  mag_t [4:0] v,
  output mag_t       med
);

  logic [4:0][2:0] rank;

  always_comb begin
    med  = '0;
    rank = '0;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        // equal values: the lower index sorts first
        if (j < i) begin
          if (v[j] <= v[i]) rank[i] = rank[i] + 3'd1;
        end else if (j > i) begin
          if (v[j] < v[i]) rank[i] = rank[i] + 3'd1;
        end
      end
    end
    for (int i = 0; i < 5; i++) begin
      if (rank[i] == 3'd2) med = v[i];
    end
  end

endmodule

>>> sv/temporal_median_of_five_filter.sv
// ----------------------------------------------------------------------------
// temporal_median_of_five_filter - per-bin median over five spectrum frames
// Line store of the last four frames, parallel rank network, result register.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one bin magnitude per transaction, bin after bin, frame after
//           frame; in_tuser flags bins of the track's final frame.
//   out_* : results; tdata carries the filtered value, its frame lag and its
//           bin index, tlast marks the last result caused by one input bin.
//   cfg_* : bins_per_frame, always ready; to be written only while the block
//           is idle, by the user; the block does not enforce this.
// Each bin is held in the compare stage, then its result in the result register.
// Throughput: one bin per cycle while each bin causes at most one result and
//   out_tready is high; a bin of the final frame causes up to three results,
//   one per cycle unless stalled, and holds the input for those extra cycles.
// The line store is one row of four magnitudes per bin, read at acceptance
// and rewritten when the bin leaves the compare stage; a row written at the
// same edge as it is read is bypassed.
// Reset clears counters and valid flags, bins_per_frame returns to 256; the
// line store is not cleared and is written before it is used.
// A stalled receiver holds the result register; bins with no result still
// pass, the first bin with a result waits in the compare stage and in_tready
// drops.
// ----------------------------------------------------------------------------
module temporal_median_of_five_filter
  import tmf_pkg::*;
#(
  parameter int MAX_BINS = 256
)
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,      // bins_per_frame
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [MAG_W-1:0]  in_tdata,      // [15:0] magnitude
  input  logic [0:0]        in_tuser,      // [0] last_frame
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,     // [15:0] filtered, [17:16] frame_lag,
                                           // [25:18] bin_index, [31:26] zero
  output logic              out_tlast      // run_end
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int WW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
  localparam int RW = 4 * MAG_W;

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] bpf_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpf_r <= CFG_RESET;
    end else if (cfg_valid) begin
      bpf_r <= cfg_data;
    end
  end

  // ------------------------------------------------------ position counters
  logic [AW-1:0]   bin_r, bin_nxt;
  logic [FS_W-1:0] fs_r, fs_nxt;
  logic [WW-1:0]   n_eff, cfg_ext, bin_inc;
  logic            in_acc, frame_end;

  assign in_acc  = in_tvalid && in_tready;
  assign cfg_ext = WW'(bpf_r);
  assign bin_inc = WW'(bin_r) + WW'(1);

  always_comb begin
    if (cfg_ext == '0)                   n_eff = WW'(1);
    else if (cfg_ext > WW'(MAX_BINS))    n_eff = WW'(MAX_BINS);
    else                                 n_eff = cfg_ext;
  end

  assign frame_end = (bin_inc >= n_eff);

  always_comb begin
    bin_nxt = bin_r;
    fs_nxt  = fs_r;
    if (in_acc) begin
      if (frame_end) begin
        bin_nxt = '0;
        if (in_tuser[0])          fs_nxt = '0;
        else if (fs_r < FS_FULL)  fs_nxt = fs_r + FS_ONE;
      end else begin
        bin_nxt = AW'(bin_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r <= '0;
      fs_r  <= '0;
    end else begin
      bin_r <= bin_nxt;
      fs_r  <= fs_nxt;
    end
  end

  // ------------------------------------------------------------- line store
  // row of one bin: [15:0] one frame back ... [63:48] four frames back
  logic [RW-1:0] hist_mem [MAX_BINS];
  logic [RW-1:0] rd_row_r, byp_row_r, row, wr_row;
  logic          byp_r;

  // ------------------------------------------------------- compare stage
  logic            s1_v_r;
  mag_t            s1_mag_r;
  logic            s1_last_r;
  logic [AW-1:0]   s1_bin_r;
  logic [FS_W-1:0] s1_fs_r;
  logic            sent2_r, sent1_r;
  logic            s1_go;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_row_r  <= hist_mem[bin_r];
      byp_r     <= s1_go && (s1_bin_r == bin_r);
      byp_row_r <= wr_row;
    end
    if (s1_go) begin
      hist_mem[s1_bin_r] <= wr_row;
    end
  end

  assign row    = byp_r ? byp_row_r : rd_row_r;
  assign wr_row = {row[3*MAG_W-1:0], s1_mag_r};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mag_r  <= in_tdata;
      s1_last_r <= in_tuser[0];
      s1_bin_r  <= bin_r;
      s1_fs_r   <= fs_r;
    end
  end

  mag_t [4:0] med_in;
  mag_t       med;

  assign med_in = {row, s1_mag_r};

  tmf_median5 u_median (
    .v   (med_in),
    .med (med)
  );

  // ----------------------------------------------------- result sequencing
  logic pend2, pend1, pend0, any_res, fin;
  lag_t sel_lag;
  mag_t sel_val;
  logic out_load;

  logic             out_v_r;
  mag_t             out_val_r;
  lag_t             out_lag_r;
  logic [BIN_W-1:0] out_bin_r;
  logic             out_last_r;

  assign out_load = !out_v_r || out_tready;

  assign pend2   = (s1_fs_r >= FS_TWO) && !sent2_r;
  assign pend1   = s1_last_r && (s1_fs_r >= FS_ONE) && !sent1_r;
  assign pend0   = s1_last_r;
  assign any_res = pend2 || pend1 || pend0;

  always_comb begin
    sel_lag = LAG_NOW;
    sel_val = '0;
    fin     = 1'b1;
    if (pend2) begin
      sel_lag = LAG_TWO;
      sel_val = (s1_fs_r >= FS_FULL) ? med : '0;
      fin     = !s1_last_r;
    end else if (pend1) begin
      sel_lag = LAG_ONE;
      fin     = 1'b0;
    end
  end

  assign s1_go     = s1_v_r && (!any_res || (out_load && fin));
  assign in_tready = !s1_v_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      sent2_r <= 1'b0;
      sent1_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (in_acc || s1_go) begin
        sent2_r <= 1'b0;
        sent1_r <= 1'b0;
      end else if (s1_v_r && any_res && out_load) begin
        if (sel_lag == LAG_TWO) sent2_r <= 1'b1;
        if (sel_lag == LAG_ONE) sent1_r <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= s1_v_r && any_res;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_v_r && any_res) begin
      out_val_r  <= sel_val;
      out_lag_r  <= sel_lag;
      out_bin_r  <= BIN_W'(s1_bin_r);
      out_last_r <= fin;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_DW'({out_bin_r, out_lag_r, out_val_r});

  // ------------------------------------------------------------- assertions
  a_fs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fs_r <= FS_FULL)
    else $error("frame counter beyond saturation");

  a_sent_held: assert property (@(posedge clk) disable iff (!rst_n)
    (sent2_r || sent1_r) |-> s1_v_r)
    else $error("partial result flags set with compare stage empty");

  a_lag0_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_lag_r == LAG_NOW) |-> out_last_r)
    else $error("lag-0 result not marked last");

  a_lag1_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_lag_r == LAG_ONE) |-> !out_last_r)
    else $error("lag-1 result marked last");

  a_accept_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_v_r) |-> s1_go)
    else $error("compare stage overwritten");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && frame_end) |=> (bin_r == '0))
    else $error("bin counter did not wrap at frame end");

endmodule
